>>> rtl/brlt_pkg.sv
// ----------------------------------------------------------------------------
// brlt_pkg
// Shared types and codes of the byte range lock table: request and result
// beats, controller commands and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package brlt_pkg;

  // request kinds
  localparam logic [1:0] KIND_LOCK   = 2'd0;
  localparam logic [1:0] KIND_UNLOCK = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_WOULDBLOCK = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_NOSUCH     = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // input beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] from_node;
    logic [31:0] header_node;
    logic [31:0] request_node;
    logic [63:0] resource_number;
    logic [63:0] lock_owner;
    logic [31:0] process_id;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic        exclusive;
    logic        may_wait;
  } brlt_in_t;

  // result beat
  typedef struct packed {
    logic [2:0]  status;
    logic        queued;
    logic [63:0] echo_resource;
    logic [63:0] echo_owner;
    logic [63:0] echo_start;
    logic [63:0] echo_end;
  } brlt_out_t;

  // one held lock or one queued waiter
  typedef struct packed {
    logic [63:0] res;
    logic [63:0] owner;
    logic [63:0] start;
    logic [63:0] stop;
    logic [31:0] node;
    logic [31:0] pid;
    logic        ex;
  } brlt_req_t;

  // decoded request class
  typedef enum logic [1:0] {
    CLS_BAD    = 2'd0,
    CLS_GET    = 2'd1,
    CLS_LOCK   = 2'd2,
    CLS_UNLOCK = 2'd3
  } brlt_cls_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       chk_start;
    logic       app_start;
    logic       slot_inc;
    logic       chk_eval;
    logic       app_eval;
    logic       add_step;
    logic       w_clr;
    logic       w_inc;
    logic       push;
    logic       load_waiter;
    logic       shift_start;
    logic       shift_rd;
    logic       shift_step;
    logic       cnt_dec;
    logic       set_status;
    logic [2:0] status;
    logic       set_queued;
  } brlt_cmd_t;

  // datapath to controller
  typedef struct packed {
    brlt_cls_t cls;
    logic      may_wait;
    logic      slot_last;
    logic      done_now;
    logic      conflict;
    logic      known;
    logic      fit;
    logic      q_full;
    logic      w_end;
    logic      w_match;
    logic      adds_left;
    logic      shift_more;
    logic      foreign;
  } brlt_stat_t;

endpackage

`default_nettype wire

>>> rtl/brlt_datapath.sv
// ----------------------------------------------------------------------------
// brlt_datapath
// Lock table and waiter queue storage, request registers, scan counters and
// the per-slot check and update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module brlt_datapath import brlt_pkg::*; #(
  parameter int LOCK_SLOTS   = 64,
  parameter int WAITER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  brlt_in_t    in_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  brlt_cmd_t   cmd,
  output brlt_stat_t  stat,
  output brlt_out_t   out_data
);

  localparam int SW  = $clog2(LOCK_SLOTS);
  localparam int FW  = $clog2(LOCK_SLOTS + 1);
  localparam int CW  = $clog2(WAITER_SLOTS + 1);
  localparam int WIW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

  typedef enum logic [2:0] {
    SH_EQUAL   = 3'd0,
    SH_EDGE    = 3'd1,
    SH_INSIDE  = 3'd2,
    SH_COVER   = 3'd3,
    SH_PARTIAL = 3'd4
  } shape_t;

  typedef struct packed {
    logic        ex;
    logic [63:0] s;
    logic [63:0] e;
  } add_t;

  // how request range [s1,e1] sits against held range [s2,e2]
  function automatic shape_t shape_of(logic [63:0] s1, logic [63:0] e1,
                                      logic [63:0] s2, logic [63:0] e2);
    shape_t sh;
    if (s1 == s2 && e1 == e2)      sh = SH_EQUAL;
    else if (s1 == s2 && e1 < e2)  sh = SH_EDGE;
    else if (s1 > s2 && e1 == e2)  sh = SH_EDGE;
    else if (s1 > s2 && e1 < e2)   sh = SH_INSIDE;
    else if (s1 <= s2 && e1 >= e2) sh = SH_COVER;
    else                           sh = SH_PARTIAL;
    return sh;
  endfunction

  // request registers
  brlt_in_t    inreq;
  brlt_req_t   cur;
  logic [63:0] start_m1;
  logic [63:0] end_p1;
  logic        op_unlock;
  logic [31:0] our_node;
  logic [2:0]  status_r;
  logic        queued_r;

  // lock table
  brlt_req_t   held_mem [LOCK_SLOTS];
  logic        held_valid [LOCK_SLOTS];
  brlt_req_t   held_q;
  logic [SW-1:0] slot;
  logic [SW-1:0] fp;
  logic        hwe;
  logic [SW-1:0] hwaddr;
  brlt_req_t   hwdata;

  // scan results
  logic          conflict;
  logic          known;
  logic          done_seen;
  logic [1:0]    need;
  logic [FW-1:0] free_cnt;
  logic [1:0]    need_eff;

  // pending inserts
  logic [1:0] add_cnt;
  add_t       add_a;
  add_t       add_b;
  logic [1:0] new_n;
  add_t       new_a;
  add_t       new_b;
  logic       set_adds;
  logic       add_do;

  // waiter queue
  brlt_req_t   wait_mem [WAITER_SLOTS];
  brlt_req_t   wq;
  logic [CW-1:0] wcount;
  logic [CW-1:0] widx;
  logic [CW-1:0] sidx;
  logic [CW:0]   sidx_p1;
  logic [WIW-1:0] wraddr;
  logic          wwe;
  logic [WIW-1:0] wwaddr;
  brlt_req_t     wwdata;

  // slot evaluation terms
  brlt_req_t d;
  logic      v;
  logic      hit_res;
  logic      own;
  logic      meet;
  shape_t    shape;
  logic      clr_v;
  brlt_req_t upd;

  assign d       = held_q;
  assign v       = held_valid[slot];
  assign hit_res = v && (d.res == cur.res);
  assign own     = hit_res && (d.node == cur.node) && (d.owner == cur.owner);
  assign meet    = !((d.stop < cur.start) || (d.start > cur.stop));
  assign shape   = shape_of(cur.start, cur.stop, d.start, d.stop);
  assign add_do  = cmd.add_step && !held_valid[fp];
  assign sidx_p1 = {1'b0, sidx} + 1'b1;

  // update of one slot during the apply scan
  always_comb begin
    upd      = d;
    hwe      = 1'b0;
    clr_v    = 1'b0;
    new_n    = 2'd0;
    new_a    = '0;
    new_b    = '0;
    set_adds = 1'b0;
    if (cmd.app_eval && own && meet) begin
      case (shape)
        SH_EQUAL: begin
          if (op_unlock) begin
            clr_v = 1'b1;
          end else begin
            upd.ex = cur.ex;
            hwe    = 1'b1;
          end
        end
        SH_EDGE: begin
          if (op_unlock) begin
            if (d.start < cur.start) upd.stop = start_m1;
            else if (d.stop > cur.stop) upd.start = end_p1;
            hwe = 1'b1;
          end else if (d.ex != cur.ex) begin
            upd.start = cur.start;
            upd.stop  = cur.stop;
            upd.ex    = cur.ex;
            hwe       = 1'b1;
            set_adds  = 1'b1;
            new_n     = 2'd1;
            new_a.ex  = ~cur.ex;
            if (d.start < cur.start) begin
              new_a.s = d.start;
              new_a.e = start_m1;
            end else begin
              new_a.s = end_p1;
              new_a.e = d.stop;
            end
          end
        end
        SH_INSIDE: begin
          if (op_unlock) begin
            upd.stop = start_m1;
            hwe      = 1'b1;
            set_adds = 1'b1;
            new_n    = 2'd1;
            new_a    = '{ex: d.ex, s: end_p1, e: d.stop};
          end else if (d.ex != cur.ex) begin
            upd.start = cur.start;
            upd.stop  = cur.stop;
            upd.ex    = cur.ex;
            hwe       = 1'b1;
            set_adds  = 1'b1;
            new_n     = 2'd2;
            new_a     = '{ex: ~cur.ex, s: d.start, e: start_m1};
            new_b     = '{ex: ~cur.ex, s: end_p1, e: d.stop};
          end
        end
        SH_COVER: begin
          clr_v = 1'b1;
        end
        default: begin
          // one-sided overlap: trim the held range
          if (d.start < cur.start) upd.stop = start_m1;
          else if (d.stop > cur.stop) upd.start = end_p1;
          hwe = 1'b1;
        end
      endcase
    end
    // no early stop: the lock itself goes in as a new entry
    if (cmd.app_eval && stat.slot_last && !stat.done_now && !op_unlock) begin
      set_adds = 1'b1;
      new_n    = 2'd1;
      new_a    = '{ex: cur.ex, s: cur.start, e: cur.stop};
    end
  end

  // table write port: slot update or insert at first free slot
  always_comb begin
    hwaddr = slot;
    hwdata = upd;
    if (add_do) begin
      hwaddr       = fp;
      hwdata       = cur;
      hwdata.start = add_a.s;
      hwdata.stop  = add_a.e;
      hwdata.ex    = add_a.ex;
    end
  end

  always_ff @(posedge clk) begin
    if (hwe || add_do) begin
      held_mem[hwaddr] <= hwdata;
    end
    held_q <= held_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOCK_SLOTS; i++) held_valid[i] <= 1'b0;
    end else begin
      if (clr_v) held_valid[slot] <= 1'b0;
      if (add_do) held_valid[fp] <= 1'b1;
    end
  end

  // waiter queue ports
  assign wraddr = cmd.shift_rd ? sidx_p1[WIW-1:0] : widx[WIW-1:0];

  always_comb begin
    wwe    = 1'b0;
    wwaddr = wcount[WIW-1:0];
    wwdata = cur;
    if (cmd.push) begin
      wwe = 1'b1;
    end else if (cmd.shift_step) begin
      wwe    = 1'b1;
      wwaddr = sidx[WIW-1:0];
      wwdata = wq;
    end
  end

  always_ff @(posedge clk) begin
    if (wwe) begin
      wait_mem[wwaddr] <= wwdata;
    end
    wq <= wait_mem[wraddr];
  end

  // request, scan and queue control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      our_node  <= '0;
      wcount    <= '0;
      widx      <= '0;
      sidx      <= '0;
      slot      <= '0;
      fp        <= '0;
      add_cnt   <= '0;
      conflict  <= 1'b0;
      known     <= 1'b0;
      done_seen <= 1'b0;
      need      <= '0;
      free_cnt  <= '0;
      op_unlock <= 1'b0;
      status_r  <= ST_OK;
      queued_r  <= 1'b0;
    end else begin
      if (cfg_we) our_node <= cfg_wdata;

      if (cmd.load_in) begin
        inreq     <= in_data;
        cur.res   <= in_data.resource_number;
        cur.owner <= in_data.lock_owner;
        cur.start <= in_data.range_start;
        cur.stop  <= in_data.range_end;
        cur.node  <= in_data.from_node;
        cur.pid   <= in_data.process_id;
        cur.ex    <= in_data.exclusive;
        start_m1  <= in_data.range_start - 64'd1;
        end_p1    <= in_data.range_end + 64'd1;
        op_unlock <= (in_data.kind == KIND_UNLOCK);
        status_r  <= ST_OK;
        queued_r  <= 1'b0;
      end
      if (cmd.load_waiter) begin
        cur       <= wq;
        start_m1  <= wq.start - 64'd1;
        end_p1    <= wq.stop + 64'd1;
        op_unlock <= 1'b0;
      end
      if (cmd.set_status) status_r <= cmd.status;
      if (cmd.set_queued) queued_r <= 1'b1;

      // slot walk
      if (cmd.chk_start || cmd.app_start) slot <= '0;
      else if (cmd.slot_inc) slot <= slot + 1'b1;

      // check scan: conflicts, resource seen, slot demand
      if (cmd.chk_start) begin
        conflict  <= 1'b0;
        known     <= 1'b0;
        done_seen <= 1'b0;
        need      <= '0;
        free_cnt  <= '0;
      end else if (cmd.chk_eval) begin
        if (!v) begin
          free_cnt <= free_cnt + 1'b1;
        end else if (hit_res) begin
          known <= 1'b1;
          if (!own && meet && (cur.ex || d.ex)) conflict <= 1'b1;
          if (own && meet && !done_seen) begin
            case (shape)
              SH_EQUAL: begin
                done_seen <= 1'b1;
                need      <= 2'd0;
              end
              SH_EDGE: begin
                done_seen <= 1'b1;
                need      <= (op_unlock || d.ex == cur.ex) ? 2'd0 : 2'd1;
              end
              SH_INSIDE: begin
                done_seen <= 1'b1;
                need      <= op_unlock ? 2'd1 : ((d.ex == cur.ex) ? 2'd0 : 2'd2);
              end
              SH_COVER: free_cnt <= free_cnt + 1'b1;
              default: ;
            endcase
          end
        end
      end

      // inserts after the apply scan
      if (cmd.app_start) begin
        fp      <= '0;
        add_cnt <= '0;
      end else if (set_adds) begin
        add_cnt <= new_n;
        add_a   <= new_a;
        add_b   <= new_b;
      end else if (add_do) begin
        add_a   <= add_b;
        add_cnt <= add_cnt - 1'b1;
      end else if (cmd.add_step) begin
        fp <= fp + 1'b1;
      end

      // waiter queue
      if (cmd.push) wcount <= wcount + 1'b1;
      else if (cmd.cnt_dec) wcount <= wcount - 1'b1;
      if (cmd.w_clr) widx <= '0;
      else if (cmd.w_inc) widx <= widx + 1'b1;
      if (cmd.shift_start) sidx <= widx;
      else if (cmd.shift_step) sidx <= sidx_p1[CW-1:0];
    end
  end

  // slot demand when the scan ran to the end
  assign need_eff = done_seen ? need : {1'b0, ~op_unlock};

  // status toward the controller
  always_comb begin
    if (inreq.from_node != inreq.header_node || inreq.from_node != inreq.request_node) begin
      stat.cls = CLS_BAD;
    end else begin
      case (inreq.kind)
        KIND_LOCK:   stat.cls = (inreq.range_start > inreq.range_end) ? CLS_BAD : CLS_LOCK;
        KIND_UNLOCK: stat.cls = (inreq.range_start > inreq.range_end) ? CLS_BAD : CLS_UNLOCK;
        KIND_GET:    stat.cls = CLS_GET;
        default:     stat.cls = CLS_BAD;
      endcase
    end
    stat.may_wait   = inreq.may_wait;
    stat.slot_last  = (slot == SW'(LOCK_SLOTS - 1));
    stat.done_now   = own && meet &&
                      (shape == SH_EQUAL || shape == SH_EDGE || shape == SH_INSIDE);
    stat.conflict   = conflict;
    stat.known      = known;
    stat.fit        = (free_cnt >= FW'(need_eff));
    stat.q_full     = (wcount >= CW'(WAITER_SLOTS));
    stat.w_end      = (widx >= wcount);
    stat.w_match    = (wq.res == inreq.resource_number);
    stat.adds_left  = (add_cnt != 2'd0);
    stat.shift_more = (sidx_p1 < {1'b0, wcount});
    stat.foreign    = (inreq.from_node != our_node);
  end

  // result beat
  assign out_data.status        = status_r;
  assign out_data.queued        = queued_r;
  assign out_data.echo_resource = inreq.resource_number;
  assign out_data.echo_owner    = inreq.lock_owner;
  assign out_data.echo_start    = inreq.range_start;
  assign out_data.echo_end      = inreq.range_end;

endmodule

`default_nettype wire

>>> rtl/brlt_ctrl.sv
// ----------------------------------------------------------------------------
// brlt_ctrl
// Sequencer of the lock table: decode, check scan, apply scan, inserts,
// waiter grant loop with queue compaction, and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module brlt_ctrl import brlt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  brlt_stat_t stat,
  output brlt_cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DEC     = 18'h00002,
    S_CHK_RD  = 18'h00004,
    S_CHK_EV  = 18'h00008,
    S_CHK_END = 18'h00010,
    S_WSC_CHK = 18'h00020,
    S_WSC_RD  = 18'h00040,
    S_WSC_EV  = 18'h00080,
    S_APP_RD  = 18'h00100,
    S_APP_EV  = 18'h00200,
    S_ADD     = 18'h00400,
    S_GNT_CHK = 18'h00800,
    S_GNT_RD  = 18'h01000,
    S_GNT_EV  = 18'h02000,
    S_SHF_CHK = 18'h04000,
    S_SHF_RD  = 18'h08000,
    S_SHF_EV  = 18'h10000,
    S_RESP    = 18'h20000
  } state_t;

  state_t state, state_next;
  logic   granting, granting_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_RESP) && !stat.foreign;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      granting <= 1'b0;
    end else begin
      state    <= state_next;
      granting <= granting_next;
    end
  end

  always_comb begin
    state_next    = state;
    granting_next = granting;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        granting_next = 1'b0;
        case (stat.cls)
          CLS_BAD: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_INVALID;
            state_next     = S_RESP;
          end
          CLS_GET: state_next = S_RESP;
          default: begin
            cmd.chk_start = 1'b1;
            state_next    = S_CHK_RD;
          end
        endcase
      end
      S_CHK_RD: state_next = S_CHK_EV;
      S_CHK_EV: begin
        cmd.chk_eval = 1'b1;
        if (stat.slot_last) begin
          state_next = S_CHK_END;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = S_CHK_RD;
        end
      end
      S_CHK_END: begin
        if (granting) begin
          if (stat.conflict || !stat.fit) begin
            cmd.w_inc  = 1'b1;
            state_next = S_GNT_CHK;
          end else begin
            cmd.app_start = 1'b1;
            state_next    = S_APP_RD;
          end
        end else if (stat.cls == CLS_LOCK) begin
          if (stat.conflict) begin
            state_next     = S_RESP;
            cmd.set_status = 1'b1;
            if (!stat.may_wait) begin
              cmd.status = ST_WOULDBLOCK;
            end else if (stat.q_full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.status     = ST_OK;
              cmd.push       = 1'b1;
              cmd.set_queued = 1'b1;
            end
          end else if (!stat.fit) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_FULL;
            state_next     = S_RESP;
          end else begin
            cmd.app_start = 1'b1;
            state_next    = S_APP_RD;
          end
        end else begin
          if (!stat.known) begin
            cmd.w_clr  = 1'b1;
            state_next = S_WSC_CHK;
          end else if (!stat.fit) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_FULL;
            state_next     = S_RESP;
          end else begin
            cmd.app_start = 1'b1;
            state_next    = S_APP_RD;
          end
        end
      end
      // look for the resource among the waiters
      S_WSC_CHK: begin
        if (stat.w_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOSUCH;
          state_next     = S_RESP;
        end else begin
          state_next = S_WSC_RD;
        end
      end
      S_WSC_RD: state_next = S_WSC_EV;
      S_WSC_EV: begin
        if (stat.w_match) begin
          if (stat.fit) begin
            cmd.app_start = 1'b1;
            state_next    = S_APP_RD;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_FULL;
            state_next     = S_RESP;
          end
        end else begin
          cmd.w_inc  = 1'b1;
          state_next = S_WSC_CHK;
        end
      end
      S_APP_RD: state_next = S_APP_EV;
      S_APP_EV: begin
        cmd.app_eval = 1'b1;
        if (stat.done_now || stat.slot_last) begin
          state_next = S_ADD;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = S_APP_RD;
        end
      end
      S_ADD: begin
        if (stat.adds_left) begin
          cmd.add_step = 1'b1;
        end else if (granting) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHF_CHK;
        end else begin
          cmd.w_clr     = 1'b1;
          granting_next = 1'b1;
          state_next    = S_GNT_CHK;
        end
      end
      // walk the waiters in order
      S_GNT_CHK: begin
        if (stat.w_end) state_next = S_RESP;
        else state_next = S_GNT_RD;
      end
      S_GNT_RD: state_next = S_GNT_EV;
      S_GNT_EV: begin
        if (stat.w_match) begin
          cmd.load_waiter = 1'b1;
          cmd.chk_start   = 1'b1;
          state_next      = S_CHK_RD;
        end else begin
          cmd.w_inc  = 1'b1;
          state_next = S_GNT_CHK;
        end
      end
      // close the gap left by a granted waiter
      S_SHF_CHK: begin
        if (stat.shift_more) begin
          state_next = S_SHF_RD;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_GNT_CHK;
        end
      end
      S_SHF_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHF_EV;
      end
      S_SHF_EV: begin
        cmd.shift_step = 1'b1;
        state_next     = S_SHF_CHK;
      end
      S_RESP: begin
        if (stat.foreign || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/byte_range_lock_table_unit.sv
// ----------------------------------------------------------------------------
// byte_range_lock_table_unit
// Byte range lock manager: lock, unlock and get requests against a table of
// held shared/exclusive range locks with a FIFO of blocked waiters.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats come in on in_valid/in_stall/in_data, one at a time; the
//   unit holds in_stall high from the beat after acceptance until its result
//   is taken. Results leave on out_valid/out_stall/out_data; requests from a
//   node other than our_node_id (cfg_we/cfg_wdata) update state silently.
//   Invalid and get requests answer straight after decode. A lock or unlock
//   walks the table once to check and, if it goes ahead, once more to apply
//   (the apply walk may stop early), then places new entries in free slots.
//   Afterwards each queued waiter is read in turn, and each waiter of the
//   same resource gets a further check walk; a granted one an apply walk and
//   queue compaction. The table is read through a single registered port,
//   so a read state comes before each slot's evaluation.
//   Reset empties the table and queue and sets our_node_id to zero; no
//   clearing pass is needed. A stalled result holds, and no new request is
//   taken until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_range_lock_table_unit import brlt_pkg::*; #(
  parameter int LOCK_SLOTS   = 64,
  parameter int WAITER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  brlt_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output brlt_out_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  brlt_cmd_t  cmd;
  brlt_stat_t stat;

  // sequencer
  brlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and evaluation
  brlt_datapath #(
    .LOCK_SLOTS   (LOCK_SLOTS),
    .WAITER_SLOTS (WAITER_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/brlt_checker.sv
// ----------------------------------------------------------------------------
// brlt_checker
// Port-level checks of the lock table unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brlt_checker import brlt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input brlt_out_t out_data
);

  // one request in flight: a new beat is held off once one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while another is in flight");

  // no request is taken while a result waits
  a_stall_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // only defined status codes leave
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_WOULDBLOCK ||
                   out_data.status == ST_INVALID || out_data.status == ST_NOSUCH ||
                   out_data.status == ST_FULL))
    else $error("undefined status code");

  // queued only together with ok
  a_queued_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.queued) |-> (out_data.status == ST_OK))
    else $error("queued beat without ok status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind byte_range_lock_table_unit brlt_checker u_brlt_checker (.*);

`default_nettype wire
